[hdl/reliable_message_sequencer_top_assert.svh]
// Assertion macros for the reliable message sequencer top level.
`ifndef RELIABLE_MESSAGE_SEQUENCER_TOP_ASSERT_SVH
`define RELIABLE_MESSAGE_SEQUENCER_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define RMS_ASSERT_IMPLY(label, cond, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("rms: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define RMS_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("rms: next-cycle check failed");

`endif

[hdl/rms_pkg.sv]
// Types, constants and codes shared by the reliable message sequencer modules.
package rms_pkg;

  localparam int unsigned HEADER_BYTES      = 16;
  localparam int unsigned MAX_PAYLOAD_BYTES = 1024;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned PADDR_W     = 3;

  localparam logic [9:0] BACKOFF_START = 10'd50;
  localparam logic [9:0] BACKOFF_MAX   = 10'd800;
  localparam logic [2:0] SEND_LIMIT    = 3'd6;

  // register index, taken from paddr bit 2
  localparam logic REG_TELEMETRY_PERIOD = 1'b0;
  localparam logic REG_BOOT_ID          = 1'b1;

  localparam logic [15:0] TELEMETRY_PERIOD_RESET = 16'd100;

  typedef enum logic [2:0] {
    ACT_EXEC_CACHE    = 3'd0,
    ACT_RESEND_CACHE  = 3'd1,
    ACT_BARE_ACK      = 3'd2,
    ACT_EXEC_UNCACHED = 3'd3,
    ACT_SEND_EVENT    = 3'd4,
    ACT_EVENT_DROPPED = 3'd5,
    ACT_TELEMETRY     = 3'd6
  } rms_action_e;

  // classified item handed from front to back
  typedef struct packed {
    logic        tick;
    logic [31:0] now_ms;
    logic        ack_flag;
    logic        reliable;
    logic        reset_flag;
    logic [15:0] seq;
    logic [15:0] ack;
    logic        has_payload;
    logic        has_event;
  } rms_item_t;

  typedef struct packed {
    rms_action_e action;
    logic [15:0] seq_out;
    logic [15:0] ack_out;
    logic [31:0] telemetry_count;
    logic        last;
  } rms_result_t;

  typedef struct packed {
    logic       session_open;
    logic       event_pending;
    logic [1:0] out_count;
  } rms_status_t;

endpackage

[hdl/rms_front.sv]
// Front end: unpacks input items, checks packet lengths and classifies them.
module rms_front import rms_pkg::*; (
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_TDATA_W-1:0] s_tdata_i,
  input  logic                  s_tuser_i,
  input  logic                  full_i,
  output logic                  push_o,
  output rms_item_t             item_o
);

  logic [15:0] frame_len;
  logic [15:0] payload_len;
  logic [16:0] needed_len;
  logic        id_ok;
  logic        pkt_ok;

  assign frame_len   = s_tdata_i[47:32];
  assign id_ok       = s_tdata_i[48];
  assign payload_len = s_tdata_i[99:84];
  assign needed_len  = {1'b0, payload_len} + 17'(HEADER_BYTES);

  assign pkt_ok = id_ok && (frame_len >= 16'(HEADER_BYTES))
                  && (needed_len <= {1'b0, frame_len})
                  && (payload_len <= 16'(MAX_PAYLOAD_BYTES));

  always_comb begin
    item_o.tick        = s_tuser_i;
    item_o.now_ms      = s_tdata_i[31:0];
    item_o.ack_flag    = s_tdata_i[49];
    item_o.reliable    = s_tdata_i[50];
    item_o.reset_flag  = s_tdata_i[51];
    item_o.seq         = s_tdata_i[67:52];
    item_o.ack         = s_tdata_i[83:68];
    item_o.has_payload = (payload_len != 16'd0);
    item_o.has_event   = (s_tdata_i[109:100] != 10'd0);
  end

  assign s_tready_o = !full_i;
  // malformed packets are dropped here and never reach the back end
  assign push_o     = s_tvalid_i && !full_i && (s_tuser_i || pkt_ok);

endmodule

[hdl/rms_queue.sv]
// Short queue of classified items between front and back end.
module rms_queue import rms_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH  // at least 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rms_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output rms_item_t item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rms_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[hdl/rms_back.sv]
// Back end: session, event and telemetry state, result generation and output buffer.
module rms_back import rms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  rms_item_t   item_i,
  output logic        pop_o,
  input  logic [15:0] telemetry_period_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output rms_result_t m_res_o,
  output rms_status_t status_o
);

  logic [15:0] rx_q, rx_d;
  logic        sess_q, sess_d;
  logic        cache_q, cache_d;
  logic [15:0] tx_q, tx_d;
  logic        ev_pend_q, ev_pend_d;
  logic [31:0] ev_due_q, ev_due_d;
  logic [9:0]  backoff_q, backoff_d;
  logic [2:0]  send_cnt_q, send_cnt_d;
  logic [31:0] tel_due_q, tel_due_d;
  logic [31:0] tel_cnt_q, tel_cnt_d;

  rms_result_t res0_q, res1_q, r0, r1, ev_res, tel_res;
  logic [1:0]  out_cnt_q, out_cnt_d;
  logic [1:0]  k;
  logic        ev_hit, tel_hit;
  logic [31:0] ev_age, tel_age;
  logic        take, out_fire;

  assign m_tvalid_o = (out_cnt_q != 2'd0);
  assign m_res_o    = res0_q;
  assign out_fire   = m_tvalid_o && m_tready_i;
  assign take       = valid_i && ((out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && m_tready_i));
  assign pop_o      = take;

  assign status_o.session_open  = sess_q;
  assign status_o.event_pending = ev_pend_q;
  assign status_o.out_count     = out_cnt_q;

  // deadline reached when now - due is in the lower half of the range
  assign ev_age  = item_i.now_ms - ev_due_q;
  assign tel_age = item_i.now_ms - tel_due_q;

  always_comb begin
    rx_d       = rx_q;
    sess_d     = sess_q;
    cache_d    = cache_q;
    tx_d       = tx_q;
    ev_pend_d  = ev_pend_q;
    ev_due_d   = ev_due_q;
    backoff_d  = backoff_q;
    send_cnt_d = send_cnt_q;
    tel_due_d  = tel_due_q;
    tel_cnt_d  = tel_cnt_q;
    ev_res     = '0;
    tel_res    = '0;
    ev_hit     = 1'b0;
    tel_hit    = 1'b0;
    r0         = '0;
    r1         = '0;
    k          = 2'd0;

    if (!item_i.tick) begin
      if (item_i.ack_flag && ev_pend_q && (item_i.ack == tx_q)) begin
        ev_pend_d = 1'b0;
      end
      if (item_i.reliable) begin
        if (item_i.reset_flag && (!sess_q || (item_i.seq != rx_q))) begin
          rx_d      = item_i.seq - 16'd1;
          sess_d    = 1'b1;
          cache_d   = 1'b0;
          ev_pend_d = 1'b0;
          tel_due_d = item_i.now_ms;
        end
        ev_hit = 1'b1;
        if (sess_d && (item_i.seq == rx_d + 16'd1)) begin
          rx_d           = item_i.seq;
          cache_d        = 1'b1;
          ev_res.action  = ACT_EXEC_CACHE;
        end else if (sess_d && (item_i.seq == rx_d) && cache_d) begin
          ev_res.action  = ACT_RESEND_CACHE;
        end else begin
          ev_res.action  = ACT_BARE_ACK;
        end
        ev_res.ack_out = rx_d;
      end else if (item_i.has_payload) begin
        ev_hit         = 1'b1;
        ev_res.action  = ACT_EXEC_UNCACHED;
        ev_res.ack_out = rx_q;
      end
    end else if (sess_q) begin
      if (ev_pend_q) begin
        if (!ev_age[31]) begin
          ev_hit         = 1'b1;
          ev_res.seq_out = tx_q;
          if (send_cnt_q >= SEND_LIMIT) begin
            ev_pend_d      = 1'b0;
            ev_res.action  = ACT_EVENT_DROPPED;
          end else begin
            ev_res.action  = ACT_SEND_EVENT;
            ev_res.ack_out = rx_q;
            send_cnt_d     = send_cnt_q + 3'd1;
            ev_due_d       = item_i.now_ms + {22'd0, backoff_q};
            if (backoff_q < BACKOFF_MAX) begin
              backoff_d = {backoff_q[8:0], 1'b0};
            end
          end
        end
      end else if (item_i.has_event) begin
        tx_d       = tx_q + 16'd1;
        ev_pend_d  = 1'b1;
        send_cnt_d = 3'd0;
        backoff_d  = BACKOFF_START;
        ev_due_d   = item_i.now_ms;
      end
      if ((telemetry_period_i != 16'd0) && !tel_age[31]) begin
        tel_hit                 = 1'b1;
        tel_due_d               = item_i.now_ms + {16'd0, telemetry_period_i};
        tel_res.action          = ACT_TELEMETRY;
        tel_res.ack_out         = rx_q;
        tel_res.telemetry_count = tel_cnt_q;
        tel_cnt_d               = tel_cnt_q + 32'd1;
      end
    end

    // telemetry comes after the event result when both fire
    r0 = ev_hit ? ev_res : tel_res;
    r1 = tel_res;
    k  = {1'b0, ev_hit} + {1'b0, tel_hit};
    r0.last = (k == 2'd1);
    r1.last = 1'b1;
  end

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (take) begin
      out_cnt_d = k;
    end else if (out_fire) begin
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q       <= '0;
      sess_q     <= 1'b0;
      cache_q    <= 1'b0;
      tx_q       <= '0;
      ev_pend_q  <= 1'b0;
      ev_due_q   <= '0;
      backoff_q  <= '0;
      send_cnt_q <= '0;
      tel_due_q  <= '0;
      tel_cnt_q  <= '0;
      out_cnt_q  <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
      if (take) begin
        rx_q       <= rx_d;
        sess_q     <= sess_d;
        cache_q    <= cache_d;
        tx_q       <= tx_d;
        ev_pend_q  <= ev_pend_d;
        ev_due_q   <= ev_due_d;
        backoff_q  <= backoff_d;
        send_cnt_q <= send_cnt_d;
        tel_due_q  <= tel_due_d;
        tel_cnt_q  <= tel_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res0_q <= r0;
      res1_q <= r1;
    end else if (out_fire) begin
      res0_q <= res1_q;
    end
  end

endmodule

[hdl/reliable_message_sequencer_top.sv]
// Reliable message sequencer: top level with configuration registers.
//
// Input stream (s_axis_*): one item per packet header (tuser 0) or poll tick
// (tuser 1). Malformed packets are discarded in the front end. Output stream
// (m_axis_*): up to two results per item, action in tuser, tlast on the final
// result of an item. APB port: telemetry period at 0x0, boot id at 0x4.
//
// Flow: an item enters the queue at acceptance; the back end takes it when its
// output buffer has room and registers its results, which drive m_axis directly.
// Throughput is one item per cycle while items give at most one result and
// m_axis_tready is high; an item with two results holds the back end until its
// first result is taken, set by the single output channel. The queue has QueueDepth entries.
//
// Reset clears session, event and telemetry state and the queue; the period
// returns to 100 ms. When m_axis_tready is low the back end holds its results
// and state, the queue fills and then s_axis_tready drops.
`include "reliable_message_sequencer_top_assert.svh"

module reliable_message_sequencer_top import rms_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // now_ms[31:0], frame_len[47:32], id_ok[48], ack_valid_bit[49],
  // reliable_bit[50], reset_bit[51], seq_in[67:52], ack_in[83:68],
  // payload_len[99:84], event_len[109:100], zero[111:110]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // seq_out[15:0], ack_out[31:16], telemetry_count[63:32]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // action[2:0]
  output logic [2:0]             m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [15:0] period_q;
  logic [31:0] boot_id_q;
  logic        cfg_wr;

  logic        push, full, q_valid, pop;
  rms_item_t   front_item, q_item;
  rms_result_t res;
  rms_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_BOOT_ID) ? boot_id_q : {16'd0, period_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= TELEMETRY_PERIOD_RESET;
      boot_id_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TELEMETRY_PERIOD) begin
        period_q <= pwdata[15:0];
      end else begin
        boot_id_q <= pwdata;
      end
    end
  end

  rms_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  rms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  rms_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (q_valid),
    .item_i             (q_item),
    .pop_o              (pop),
    .telemetry_period_i (period_q),
    .m_tvalid_o         (m_axis_tvalid),
    .m_tready_i         (m_axis_tready),
    .m_res_o            (res),
    .status_o           (status)
  );

  assign m_axis_tdata = {res.telemetry_count, res.ack_out, res.seq_out};
  assign m_axis_tuser = res.action;
  assign m_axis_tlast = res.last;

  // tick-driven results only ever appear inside an open session
  `RMS_ASSERT_IMPLY(a_tick_result_in_session,
    m_axis_tvalid && ((res.action == ACT_SEND_EVENT) || (res.action == ACT_EVENT_DROPPED)
    || (res.action == ACT_TELEMETRY)), status.session_open)
  `RMS_ASSERT_IMPLY(a_event_needs_session, status.event_pending, status.session_open)
  // a non-final result always has its partner buffered behind it
  `RMS_ASSERT_IMPLY(a_not_last_has_partner, m_axis_tvalid && !m_axis_tlast,
    status.out_count == 2'd2)
  `RMS_ASSERT_NEXT(a_session_stays_open, status.session_open, status.session_open)

endmodule
